/* design/guarded_integer_stack_alu_macros.svh */
// assertion helpers used by the stack alu datapath
`ifndef GUARDED_INTEGER_STACK_ALU_MACROS_SVH
`define GUARDED_INTEGER_STACK_ALU_MACROS_SVH

// plain property, checked on every clock edge outside reset
`define GISA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gisa: property failed");

// same-cycle implication
`define GISA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gisa: implication failed");

`endif

/* design/gisa_pkg.sv */
`default_nettype none

package gisa_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned DEPTH_W     = 5;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DIV_STEPS   = DATA_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 3'd0,
    FUNC_POP  = 3'd1,
    FUNC_ADD  = 3'd2,
    FUNC_SUB  = 3'd3,
    FUNC_MUL  = 3'd4,
    FUNC_DIV  = 3'd5
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NEAR_FULL = 2'd2,
    ST_ERROR     = 2'd3
  } stat_e;

  // datapath action of one microcode step
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_PUSH,
    ACT_RD_TOP,
    ACT_RD_NEXT,
    ACT_LATCH_B,
    ACT_ADDSUB,
    ACT_MUL,
    ACT_DIV_START,
    ACT_DIV_RESULT,
    ACT_WRITE_RES,
    ACT_POP_RESULT,
    ACT_REJ_ERR,
    ACT_REJ_QUIET,
    ACT_EMIT
  } act_e;

  // sequencing of one microcode step
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_WAIT_IN,
    JMP_WAIT_DIV,
    JMP_WAIT_OUT,
    JMP_DISPATCH_OP,
    JMP_DISPATCH_ARITH
  } jmp_e;

  localparam int unsigned UADDR_W = 5;

  localparam logic [UADDR_W-1:0] U_FETCH     = 5'd0;
  localparam logic [UADDR_W-1:0] U_DECODE    = 5'd1;
  localparam logic [UADDR_W-1:0] U_PUSH      = 5'd2;
  localparam logic [UADDR_W-1:0] U_POP_RD    = 5'd3;
  localparam logic [UADDR_W-1:0] U_POP_WB    = 5'd4;
  localparam logic [UADDR_W-1:0] U_AR_RDT    = 5'd5;
  localparam logic [UADDR_W-1:0] U_AR_RDN    = 5'd6;
  localparam logic [UADDR_W-1:0] U_AR_LB     = 5'd7;
  localparam logic [UADDR_W-1:0] U_AR_SEL    = 5'd8;
  localparam logic [UADDR_W-1:0] U_ADDSUB    = 5'd9;
  localparam logic [UADDR_W-1:0] U_MUL       = 5'd10;
  localparam logic [UADDR_W-1:0] U_DIV_GO    = 5'd11;
  localparam logic [UADDR_W-1:0] U_DIV_WAIT  = 5'd12;
  localparam logic [UADDR_W-1:0] U_WRITE     = 5'd13;
  localparam logic [UADDR_W-1:0] U_REJ_ERR   = 5'd14;
  localparam logic [UADDR_W-1:0] U_REJ_QUIET = 5'd15;
  localparam logic [UADDR_W-1:0] U_EMIT      = 5'd16;

  typedef struct packed {
    act_e                act;
    jmp_e                jmp;
    logic [UADDR_W-1:0]  target;
  } ucode_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    act_e act;
  } ctrl_t;

  // conditions from the datapath back to the sequencer
  typedef struct packed {
    logic              in_valid;
    logic              out_free;
    logic              div_done;
    logic              b_zero;
    logic [FUNC_W-1:0] func;
    logic [CNT_W-1:0]  cnt;
  } stat_t;

  // microcode rom
  function automatic ucode_t ucode_rom(input logic [UADDR_W-1:0] addr);
    ucode_t uc;
    uc = '{act: ACT_NONE, jmp: JMP_GOTO, target: U_FETCH};
    case (addr)
      U_FETCH:     uc = '{act: ACT_ACCEPT,     jmp: JMP_WAIT_IN,        target: U_DECODE};
      U_DECODE:    uc = '{act: ACT_NONE,       jmp: JMP_DISPATCH_OP,    target: U_FETCH};
      U_PUSH:      uc = '{act: ACT_PUSH,       jmp: JMP_GOTO,           target: U_EMIT};
      U_POP_RD:    uc = '{act: ACT_RD_TOP,     jmp: JMP_NEXT,           target: U_FETCH};
      U_POP_WB:    uc = '{act: ACT_POP_RESULT, jmp: JMP_GOTO,           target: U_EMIT};
      U_AR_RDT:    uc = '{act: ACT_RD_TOP,     jmp: JMP_NEXT,           target: U_FETCH};
      U_AR_RDN:    uc = '{act: ACT_RD_NEXT,    jmp: JMP_NEXT,           target: U_FETCH};
      U_AR_LB:     uc = '{act: ACT_LATCH_B,    jmp: JMP_NEXT,           target: U_FETCH};
      U_AR_SEL:    uc = '{act: ACT_NONE,       jmp: JMP_DISPATCH_ARITH, target: U_FETCH};
      U_ADDSUB:    uc = '{act: ACT_ADDSUB,     jmp: JMP_GOTO,           target: U_WRITE};
      U_MUL:       uc = '{act: ACT_MUL,        jmp: JMP_GOTO,           target: U_WRITE};
      U_DIV_GO:    uc = '{act: ACT_DIV_START,  jmp: JMP_NEXT,           target: U_FETCH};
      U_DIV_WAIT:  uc = '{act: ACT_DIV_RESULT, jmp: JMP_WAIT_DIV,       target: U_WRITE};
      U_WRITE:     uc = '{act: ACT_WRITE_RES,  jmp: JMP_GOTO,           target: U_EMIT};
      U_REJ_ERR:   uc = '{act: ACT_REJ_ERR,    jmp: JMP_GOTO,           target: U_EMIT};
      U_REJ_QUIET: uc = '{act: ACT_REJ_QUIET,  jmp: JMP_GOTO,           target: U_EMIT};
      U_EMIT:      uc = '{act: ACT_EMIT,       jmp: JMP_WAIT_OUT,       target: U_FETCH};
      default:     uc = '{act: ACT_NONE,       jmp: JMP_GOTO,           target: U_FETCH};
    endcase
    return uc;
  endfunction

endpackage

`default_nettype wire

/* design/gisa_if.sv */
`default_nettype none

interface gisa_in_if
  import gisa_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface gisa_out_if
  import gisa_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [DEPTH_W-1:0]       stack_depth;
  logic [STAT_W-1:0]        status_code;
  logic                     rejected;

  modport source (output valid, output result_value, output stack_depth,
                  output status_code, output rejected, input ready);
  modport sink   (input valid, input result_value, input stack_depth,
                  input status_code, input rejected, output ready);
endinterface

`default_nettype wire

/* design/gisa_ram.sv */
`default_nettype none

module gisa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/gisa_div.sv */
`default_nettype none

module gisa_div
  import gisa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] num_i,
  input  wire logic [DATA_W-1:0] den_i,
  output      logic              done_o,
  output      logic [DATA_W-1:0] quot_o
);

  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [DATA_W-1:0]    rem_q;
  logic [DATA_W-1:0]    quo_q;
  logic [DATA_W-1:0]    den_q;
  logic                 neg_q;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      shifted;

  // one restoring step per cycle on the magnitudes
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DIV_CNT_W'(DIV_STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[DATA_W-1] ? (DATA_W'(0) - num_i) : num_i;
      den_q <= den_i[DATA_W-1] ? (DATA_W'(0) - den_i) : den_i;
      neg_q <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
    end else if (cnt_q != '0) begin
      if (!trial[DATA_W]) begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

/* design/gisa_seq.sv */
`default_nettype none

module gisa_seq
  import gisa_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire stat_t stat_i,
  output      ctrl_t ctrl_o
);

  logic [UADDR_W-1:0] upc_q;
  logic [UADDR_W-1:0] upc_d;
  ucode_t             uc;

  // bounds guard on the operation code
  function automatic logic [UADDR_W-1:0] dispatch_op(input logic [FUNC_W-1:0] func,
                                                     input logic [CNT_W-1:0]  cnt);
    logic [UADDR_W-1:0] tgt;
    tgt = U_REJ_QUIET;
    case (func)
      FUNC_PUSH: tgt = (cnt >= CNT_W'(STACK_DEPTH)) ? U_REJ_ERR : U_PUSH;
      FUNC_POP:  tgt = (cnt == '0) ? U_REJ_ERR : U_POP_RD;
      FUNC_ADD,
      FUNC_SUB,
      FUNC_MUL,
      FUNC_DIV:  tgt = (cnt < CNT_W'(2)) ? U_REJ_ERR : U_AR_RDT;
      default:   tgt = U_REJ_QUIET;
    endcase
    return tgt;
  endfunction

  // operands are loaded, pick the unit or refuse a divide by zero
  function automatic logic [UADDR_W-1:0] dispatch_arith(input logic [FUNC_W-1:0] func,
                                                        input logic              b_zero);
    logic [UADDR_W-1:0] tgt;
    tgt = U_ADDSUB;
    case (func)
      FUNC_MUL: tgt = U_MUL;
      FUNC_DIV: tgt = b_zero ? U_REJ_ERR : U_DIV_GO;
      default:  tgt = U_ADDSUB;
    endcase
    return tgt;
  endfunction

  always_comb begin
    uc = ucode_rom(upc_q);
  end

  always_comb begin
    ctrl_o.act = uc.act;
  end

  always_comb begin
    upc_d = upc_q;
    case (uc.jmp)
      JMP_NEXT:           upc_d = upc_q + 1'b1;
      JMP_GOTO:           upc_d = uc.target;
      JMP_WAIT_IN:        upc_d = stat_i.in_valid ? uc.target : upc_q;
      JMP_WAIT_DIV:       upc_d = stat_i.div_done ? uc.target : upc_q;
      JMP_WAIT_OUT:       upc_d = stat_i.out_free ? uc.target : upc_q;
      JMP_DISPATCH_OP:    upc_d = dispatch_op(stat_i.func, stat_i.cnt);
      JMP_DISPATCH_ARITH: upc_d = dispatch_arith(stat_i.func, stat_i.b_zero);
      default:            upc_d = U_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

/* design/gisa_dp.sv */
`default_nettype none

`include "guarded_integer_stack_alu_macros.svh"

module gisa_dp
  import gisa_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire ctrl_t ctrl_i,
  output      stat_t stat_o,
  gisa_in_if.sink    req_i,
  gisa_out_if.source rsp_o
);

  logic [CNT_W-1:0]   count_q;
  logic               err_q;
  logic               out_valid_q;
  logic [FUNC_W-1:0]  func_q;
  logic [DATA_W-1:0]  val_q;
  logic [DATA_W-1:0]  a_q;
  logic [DATA_W-1:0]  b_q;
  logic [DATA_W-1:0]  res_q;
  logic               rej_q;
  logic [DATA_W-1:0]  out_res_q;
  logic [DEPTH_W-1:0] out_depth_q;
  logic [STAT_W-1:0]  out_stat_q;
  logic               out_rej_q;

  logic               in_xfer;
  logic               out_free;
  logic               emit;
  logic [ADDR_W-1:0]  top_idx;
  logic [ADDR_W-1:0]  next_idx;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;
  logic               div_done;
  logic [DATA_W-1:0]  div_quot;
  stat_e              status;

  assign in_xfer  = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign emit     = (ctrl_i.act == ACT_EMIT) && out_free;
  assign top_idx  = ADDR_W'(count_q - CNT_W'(1));
  assign next_idx = ADDR_W'(count_q - CNT_W'(2));

  assign req_i.ready = (ctrl_i.act == ACT_ACCEPT);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = next_idx;
    ram_wdata = res_q;
    ram_raddr = top_idx;
    case (ctrl_i.act)
      ACT_PUSH: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(count_q);
        ram_wdata = val_q;
      end
      ACT_WRITE_RES: begin
        ram_we = 1'b1;
      end
      ACT_RD_NEXT: begin
        ram_raddr = next_idx;
      end
      default: begin
      end
    endcase
  end

  gisa_ram #(
    .Width (DATA_W),
    .Depth (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gisa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.act == ACT_DIV_START),
    .num_i   (a_q),
    .den_i   (b_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    if (err_q) begin
      status = ST_ERROR;
    end else if (count_q == '0) begin
      status = ST_EMPTY;
    end else if (count_q == CNT_W'(STACK_DEPTH - 1)) begin
      status = ST_NEAR_FULL;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (ctrl_i.act)
        ACT_PUSH:       count_q <= count_q + 1'b1;
        ACT_POP_RESULT,
        ACT_WRITE_RES:  count_q <= count_q - 1'b1;
        ACT_REJ_ERR:    err_q   <= 1'b1;
        default: begin
        end
      endcase
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.act)
      ACT_ACCEPT: begin
        if (in_xfer) begin
          func_q <= req_i.func;
          val_q  <= $unsigned(req_i.push_value);
          rej_q  <= 1'b0;
        end
      end
      ACT_PUSH:       res_q <= val_q;
      ACT_POP_RESULT: res_q <= ram_rdata;
      ACT_RD_NEXT:    a_q   <= ram_rdata;
      ACT_LATCH_B:    b_q   <= ram_rdata;
      ACT_ADDSUB:     res_q <= (func_q == FUNC_SUB) ? (a_q - b_q) : (a_q + b_q);
      ACT_MUL:        res_q <= DATA_W'(a_q * b_q);
      ACT_DIV_RESULT: res_q <= div_quot;
      ACT_REJ_ERR,
      ACT_REJ_QUIET: begin
        res_q <= '0;
        rej_q <= 1'b1;
      end
      default: begin
      end
    endcase
    if (emit) begin
      out_res_q   <= res_q;
      out_depth_q <= DEPTH_W'(count_q);
      out_stat_q  <= status;
      out_rej_q   <= rej_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = $signed(out_res_q);
  assign rsp_o.stack_depth  = out_depth_q;
  assign rsp_o.status_code  = out_stat_q;
  assign rsp_o.rejected     = out_rej_q;

  assign stat_o.in_valid = req_i.valid;
  assign stat_o.out_free = out_free;
  assign stat_o.div_done = div_done;
  assign stat_o.b_zero   = (b_q == '0);
  assign stat_o.func     = func_q;
  assign stat_o.cnt      = count_q;

  `GISA_ASSERT(a_err_sticky, err_q |=> err_q)
  `GISA_ASSERT(a_cnt_bound, count_q <= CNT_W'(STACK_DEPTH))
  `GISA_ASSERT_IMP(a_push_room, ctrl_i.act == ACT_PUSH, count_q < CNT_W'(STACK_DEPTH))
  `GISA_ASSERT_IMP(a_write_two, ctrl_i.act == ACT_WRITE_RES, count_q >= CNT_W'(2))
  `GISA_ASSERT_IMP(a_rej_zero, out_valid_q && out_rej_q, out_res_q == '0)

endmodule

`default_nettype wire

/* design/guarded_integer_stack_alu.sv */
`default_nettype none

// Integer stack calculator with bounds guarding. Each transfer on req_i carries one
// operation (push, pop, add, subtract, multiply, divide); subtract and divide take the
// top entry as the left operand. Arithmetic wraps at 32 bits and division truncates
// toward zero. Overflow, underflow and divide by zero are refused with the stack left
// as it was and a sticky error raised in status_code; unused codes are refused without
// the error. Every operation returns exactly one transfer on rsp_o. A microcoded
// sequencer runs one step per clock, repeating a step while it waits on req_i, the
// divider or rsp_o, and takes one operation at a time. Divide takes longest, most of
// its time spent in the 32-step iterative divider. The stack lives in a 16-entry
// RAM with a registered read port. A result waiting on rsp_o does not block
// acceptance of the next operation, but that operation holds in its final step
// until the waiting result has been taken.

module guarded_integer_stack_alu
  import gisa_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gisa_in_if.sink    req_i,
  gisa_out_if.source rsp_o
);

  ctrl_t ctrl;
  stat_t stat;

  gisa_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  gisa_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire
